FILE: design/hrcf_pkg.sv
package hrcf_pkg;

    localparam int MAX_BINS   = 1024;
    localparam int POS_W      = $clog2(MAX_BINS + 1);
    localparam int COUNT_W    = 16;
    localparam int RUN_POS_W  = 11;
    localparam int WEIGHT_W   = 26;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};
    localparam logic [POS_W-1:0]    LAST_POS   = POS_W'(MAX_BINS);

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [COUNT_W-1:0] bin_count;
        logic               last_bin;
    } hrcf_in_t;

    typedef struct packed {
        logic [RUN_POS_W-1:0] run_start_bin;
        logic [RUN_POS_W-1:0] run_end_bin;
        logic [COUNT_W-1:0]   run_peak_height;
        logic [RUN_POS_W-1:0] run_peak_bin;
        logic [WEIGHT_W-1:0]  run_weight;
    } hrcf_out_t;

    // item handed from the input stage to the run tracker
    typedef struct packed {
        logic     valid;
        hrcf_in_t item;
    } hrcf_bin_t;

    // record offered by the run tracker
    typedef struct packed {
        logic      valid;
        hrcf_out_t rec;
    } hrcf_rec_t;

endpackage

FILE: design/hrcf_in_stage.sv
module hrcf_in_stage import hrcf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  hrcf_in_t  s_item,
    input  logic      advance,
    output hrcf_bin_t bin_out
);

    logic     valid_reg;
    logic     valid_next;
    hrcf_in_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign bin_out.valid = valid_reg;
    assign bin_out.item  = item_reg;

endmodule

FILE: design/hrcf_run_tracker.sv
module hrcf_run_tracker import hrcf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  hrcf_bin_t bin_in,
    input  logic      advance,
    output hrcf_rec_t rec_out
);

    logic                prev_nz_reg, prev_nz_next;
    pos_t                bin_pos_reg, bin_pos_next;
    pos_t                start_reg, start_next;
    logic [WEIGHT_W-1:0] sum_reg, sum_next;
    logic [COUNT_W-1:0]  peak_reg, peak_next;
    pos_t                peak_pos_reg, peak_pos_next;

    logic [COUNT_W-1:0]  cnt;
    pos_t                pos;
    logic                last;
    logic                nz;
    pos_t                base_start, base_peak_pos;
    logic [WEIGHT_W-1:0] base_sum, new_sum;
    logic [WEIGHT_W:0]   sum_add;
    logic [COUNT_W-1:0]  base_peak, new_peak;
    pos_t                new_peak_pos;
    logic                step;

    assign step = bin_in.valid && advance;
    assign cnt  = bin_in.item.bin_count;
    assign pos  = bin_pos_reg + 1'b1;
    assign last = bin_in.item.last_bin || (pos >= LAST_POS);
    assign nz   = (cnt != '0);

    // a fresh run starts from zeroed accumulators
    assign base_start    = prev_nz_reg ? start_reg    : pos;
    assign base_sum      = prev_nz_reg ? sum_reg      : '0;
    assign base_peak     = prev_nz_reg ? peak_reg     : '0;
    assign base_peak_pos = prev_nz_reg ? peak_pos_reg : '0;

    assign sum_add      = {1'b0, base_sum} + (WEIGHT_W + 1)'(cnt);
    assign new_sum      = sum_add[WEIGHT_W] ? WEIGHT_MAX : sum_add[WEIGHT_W-1:0];
    assign new_peak     = (cnt > base_peak) ? cnt : base_peak;
    assign new_peak_pos = (cnt > base_peak) ? pos : base_peak_pos;

    always_comb begin
        rec_out.valid = 1'b0;
        rec_out.rec   = '0;
        if (nz) begin
            rec_out.valid               = bin_in.valid && last && (new_peak >= COUNT_W'(2));
            rec_out.rec.run_start_bin   = RUN_POS_W'(base_start);
            rec_out.rec.run_end_bin     = RUN_POS_W'(pos);
            rec_out.rec.run_peak_height = new_peak;
            rec_out.rec.run_peak_bin    = RUN_POS_W'(new_peak_pos);
            rec_out.rec.run_weight      = new_sum;
        end else begin
            // zero bin closes the open run at the previous position
            rec_out.valid               = bin_in.valid && prev_nz_reg;
            rec_out.rec.run_start_bin   = RUN_POS_W'(start_reg);
            rec_out.rec.run_end_bin     = RUN_POS_W'(bin_pos_reg);
            rec_out.rec.run_peak_height = peak_reg;
            rec_out.rec.run_peak_bin    = RUN_POS_W'(peak_pos_reg);
            rec_out.rec.run_weight      = sum_reg;
        end
    end

    always_comb begin
        prev_nz_next  = prev_nz_reg;
        bin_pos_next  = bin_pos_reg;
        start_next    = start_reg;
        sum_next      = sum_reg;
        peak_next     = peak_reg;
        peak_pos_next = peak_pos_reg;
        if (step) begin
            if (last) begin
                prev_nz_next  = 1'b0;
                bin_pos_next  = '0;
                start_next    = '0;
                sum_next      = '0;
                peak_next     = '0;
                peak_pos_next = '0;
            end else begin
                bin_pos_next = pos;
                prev_nz_next = nz;
                if (nz) begin
                    start_next    = base_start;
                    sum_next      = new_sum;
                    peak_next     = new_peak;
                    peak_pos_next = new_peak_pos;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_nz_reg  <= 1'b0;
            bin_pos_reg  <= '0;
            start_reg    <= '0;
            sum_reg      <= '0;
            peak_reg     <= '0;
            peak_pos_reg <= '0;
        end else begin
            prev_nz_reg  <= prev_nz_next;
            bin_pos_reg  <= bin_pos_next;
            start_reg    <= start_next;
            sum_reg      <= sum_next;
            peak_reg     <= peak_next;
            peak_pos_reg <= peak_pos_next;
        end
    end

endmodule

FILE: design/histogram_run_cluster_finder.sv
// Streams histogram bins, one item per clock while no record waits on
// m_ready, and reports each run of consecutive nonzero bins as one record
// (start, end, peak, first peak bin, saturated sum). The rate is one bin per
// cycle, set by the run-tracker update (one 26-bit saturating add and a
// 16-bit peak compare); the bin that closes a run is registered in the input
// stage and its record in the output register, and while a record waits on
// m_ready the whole pipe holds. A zero bin closes a run; a run still open at
// the last bin (or at bin MAX_BINS) is reported only if its peak is at least
// 2. Positions count from 1 and restart after every last bin.
module histogram_run_cluster_finder import hrcf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  hrcf_in_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output hrcf_out_t m_item
);

    hrcf_bin_t bin;
    hrcf_rec_t rec;
    logic      advance;
    logic      m_valid_reg, m_valid_next;
    hrcf_out_t m_item_reg;

    assign advance = !m_valid_reg || m_ready;

    hrcf_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .advance (advance),
        .bin_out (bin)
    );

    hrcf_run_tracker u_run_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .bin_in  (bin),
        .advance (advance),
        .rec_out (rec)
    );

    assign m_valid_next = advance ? rec.valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && rec.valid) begin
            m_item_reg <= rec.rec;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

FILE: bench/histogram_run_cluster_finder_tb.sv
`timescale 1ns / 100ps

module histogram_run_cluster_finder_tb;
    import hrcf_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BINS  = 750;
    localparam int DRAIN_EVERY  = 200;
    localparam int TAIL_CYCLES  = 20;
    localparam int REPORT_LIMIT = 10;

    localparam hrcf_out_t NO_REC = '0;

    // one directed item; when 'typed' is set the expected record is given here
    typedef struct packed {
        hrcf_in_t  item;
        logic      typed;
        logic      hit;
        hrcf_out_t rec;
    } dir_row_t;

    localparam int NUM_DIR = 25;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    hrcf_in_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    hrcf_out_t m_item;

    histogram_run_cluster_finder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #4 aclk = ~aclk;

    // run tracker state of the predictor
    logic                 trk_open;
    logic [RUN_POS_W-1:0] trk_pos;
    logic [RUN_POS_W-1:0] trk_start;
    logic [WEIGHT_W-1:0]  trk_sum;
    logic [COUNT_W-1:0]   trk_peak;
    logic [RUN_POS_W-1:0] trk_peak_pos;

    hrcf_out_t run_records_due[$];

    int  fail_count = 0;
    int  cycle_count = 0;
    int  bins_sent = 0;
    int  hists_sent = 0;
    int  records_seen = 0;
    bit  pace_on = 1'b1;
    int  stall_left = 0;

    dir_row_t dir_rows [NUM_DIR] = '{
        // single bin run closed by a zero
        '{'{16'd5, 1'b0}, 1'b1, 1'b0, NO_REC},
        '{'{16'd0, 1'b0}, 1'b1, 1'b1, '{11'd1, 11'd1, 16'd5, 11'd1, 26'd5}},
        // full-scale counts, tied peak keeps the first bin
        '{'{16'hFFFF, 1'b0}, 1'b1, 1'b0, NO_REC},
        '{'{16'hFFFF, 1'b0}, 1'b1, 1'b0, NO_REC},
        '{'{16'd1, 1'b0}, 1'b1, 1'b0, NO_REC},
        '{'{16'd0, 1'b0}, 1'b1, 1'b1, '{11'd3, 11'd5, 16'hFFFF, 11'd3, 26'd131071}},
        // run still open at the last bin with peak 1: dropped
        '{'{16'd1, 1'b0}, 1'b1, 1'b0, NO_REC},
        '{'{16'd1, 1'b1}, 1'b1, 1'b0, NO_REC},
        // last bin zero closes the run as usual
        '{'{16'd0, 1'b0}, 1'b1, 1'b0, NO_REC},
        '{'{16'd2, 1'b0}, 1'b1, 1'b0, NO_REC},
        '{'{16'd0, 1'b1}, 1'b1, 1'b1, '{11'd2, 11'd2, 16'd2, 11'd2, 26'd2}},
        // peak-1 run closed by a zero is still reported
        '{'{16'd1, 1'b0}, 1'b1, 1'b0, NO_REC},
        '{'{16'd0, 1'b0}, 1'b1, 1'b1, '{11'd1, 11'd1, 16'd1, 11'd1, 26'd1}},
        '{'{16'd3, 1'b0}, 1'b1, 1'b0, NO_REC},
        '{'{16'd7, 1'b0}, 1'b1, 1'b0, NO_REC},
        '{'{16'd7, 1'b1}, 1'b1, 1'b1, '{11'd3, 11'd5, 16'd7, 11'd4, 26'd17}},
        // one-bin histograms
        '{'{16'd2, 1'b1}, 1'b1, 1'b1, '{11'd1, 11'd1, 16'd2, 11'd1, 26'd2}},
        '{'{16'd1, 1'b1}, 1'b1, 1'b0, NO_REC},
        '{'{16'd0, 1'b1}, 1'b1, 1'b0, NO_REC},
        // bit patterns, left to the predictor
        '{'{16'h8000, 1'b0}, 1'b0, 1'b0, NO_REC},
        '{'{16'h7FFF, 1'b0}, 1'b0, 1'b0, NO_REC},
        '{'{16'hAAAA, 1'b0}, 1'b0, 1'b0, NO_REC},
        '{'{16'h5555, 1'b0}, 1'b0, 1'b0, NO_REC},
        '{'{16'd0, 1'b1}, 1'b0, 1'b0, NO_REC},
        '{'{16'hFFFF, 1'b1}, 1'b1, 1'b1, '{11'd1, 11'd1, 16'hFFFF, 11'd1, 26'd65535}}
    };

    function automatic void clear_tracker();
        trk_open     = 1'b0;
        trk_pos      = '0;
        trk_start    = '0;
        trk_sum      = '0;
        trk_peak     = '0;
        trk_peak_pos = '0;
    endfunction

    // advance the tracker by one bin; returns 1 when a run record is due
    function automatic bit track_bin(input hrcf_in_t it, output hrcf_out_t rec);
        logic [RUN_POS_W-1:0] pos;
        logic [WEIGHT_W:0]    wide_sum;
        bit                   closing;
        bit                   hit;
        pos     = trk_pos + 1'b1;
        closing = it.last_bin || (int'(pos) >= MAX_BINS);
        hit     = 1'b0;
        rec     = '0;
        if (it.bin_count != '0) begin
            if (!trk_open) begin
                trk_start    = pos;
                trk_sum      = '0;
                trk_peak     = '0;
                trk_peak_pos = '0;
            end
            wide_sum = {1'b0, trk_sum} + (WEIGHT_W + 1)'(it.bin_count);
            trk_sum  = wide_sum[WEIGHT_W] ? WEIGHT_MAX : wide_sum[WEIGHT_W-1:0];
            if (it.bin_count > trk_peak) begin
                trk_peak     = it.bin_count;
                trk_peak_pos = pos;
            end
            if (closing && trk_peak >= COUNT_W'(2)) begin
                rec = '{trk_start, pos, trk_peak, trk_peak_pos, trk_sum};
                hit = 1'b1;
            end
            trk_open = 1'b1;
        end else begin
            if (trk_open) begin
                rec = '{trk_start, pos - 1'b1, trk_peak, trk_peak_pos, trk_sum};
                hit = 1'b1;
            end
            trk_open = 1'b0;
        end
        if (closing)
            clear_tracker();
        else
            trk_pos = pos;
        return hit;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 93)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [COUNT_W-1:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return '0;
        else if (r < 60)
            return COUNT_W'(1);
        else if (r < 78)
            return COUNT_W'($urandom_range(2, 6));
        else
            return COUNT_W'($urandom_range(0, 65535));
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
    endfunction

    task automatic send_bin(hrcf_in_t it, bit typed, bit typed_hit, hrcf_out_t typed_rec);
        int        gap;
        bit        hit;
        hrcf_out_t rec;
        gap = (pace_on && $urandom_range(0, 99) >= 60) ? gap_len() : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        hit = track_bin(it, rec);
        if (typed) begin
            hit = typed_hit;
            rec = typed_rec;
        end
        if (hit)
            run_records_due = {run_records_due, rec};
        bins_sent++;
        if (it.last_bin)
            hists_sent++;
    endtask

    task automatic wait_records_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (run_records_due.size() != 0)
            @(posedge aclk);
    endtask

    // result side: random back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (pace_on && $urandom_range(0, 99) < 20)
                stall_left <= gap_len();
        end
    end

    always @(posedge aclk) begin
        hrcf_out_t want;
        if (aresetn && m_valid && m_ready) begin
            records_seen++;
            if (run_records_due.size() == 0) begin
                note_failure($sformatf("unexpected record start=%0d end=%0d peak=%0d pbin=%0d w=%0d",
                    m_item.run_start_bin, m_item.run_end_bin, m_item.run_peak_height,
                    m_item.run_peak_bin, m_item.run_weight));
            end else begin
                want = run_records_due.pop_front();
                if (m_item.run_start_bin !== want.run_start_bin ||
                    m_item.run_end_bin !== want.run_end_bin ||
                    m_item.run_peak_height !== want.run_peak_height ||
                    m_item.run_peak_bin !== want.run_peak_bin ||
                    m_item.run_weight !== want.run_weight)
                    note_failure($sformatf({"record mismatch exp start=%0d end=%0d peak=%0d ",
                        "pbin=%0d w=%0d got start=%0d end=%0d peak=%0d pbin=%0d w=%0d"},
                        want.run_start_bin, want.run_end_bin, want.run_peak_height,
                        want.run_peak_bin, want.run_weight,
                        m_item.run_start_bin, m_item.run_end_bin, m_item.run_peak_height,
                        m_item.run_peak_bin, m_item.run_weight));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL histogram_run_cluster_finder");
            $finish;
        end
    end

    initial begin
        hrcf_in_t it;
        int       len;
        int       rand_bins;
        int       next_drain;
        rand_bins  = 0;
        next_drain = DRAIN_EVERY;
        clear_tracker();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_bin(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].hit, dir_rows[i].rec);
        wait_records_drained();

        // random histograms, mostly short; sender holds off every so often
        while (rand_bins < RANDOM_BINS) begin
            pace_on = ($urandom_range(0, 4) != 0);
            len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 24) : $urandom_range(25, 120);
            for (int i = 0; i < len; i++) begin
                it.bin_count = rand_count();
                it.last_bin  = (i == len - 1);
                send_bin(it, 1'b0, 1'b0, NO_REC);
                rand_bins++;
            end
            if (rand_bins >= next_drain) begin
                wait_records_drained();
                next_drain += DRAIN_EVERY;
            end
            // one full-length histogram with no last flag; ends on a tall run
            if (rand_bins >= RANDOM_BINS / 4 && hists_sent > 0 && len > 0 &&
                rand_bins - len < RANDOM_BINS / 4) begin
                pace_on = 1'b1;
                for (int i = 0; i < MAX_BINS; i++) begin
                    it.bin_count = (i >= MAX_BINS - 3) ? COUNT_W'($urandom_range(2, 9)) :
                                                         rand_count();
                    it.last_bin  = 1'b0;
                    send_bin(it, 1'b0, 1'b0, NO_REC);
                    rand_bins++;
                end
                hists_sent++;
            end
        end

        wait_records_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (run_records_due.size() != 0)
            note_failure($sformatf("%0d run records never arrived", run_records_due.size()));

        $display("Sent %0d bins in %0d histograms, including one that ran to MAX_BINS unflagged.",
            bins_sent, hists_sent);
        $display("Checked %0d run records with random gaps and back-pressure; %0d failures.",
            records_seen, fail_count);
        if (fail_count == 0)
            $display("PASS histogram_run_cluster_finder");
        else
            $display("FAIL histogram_run_cluster_finder");
        $finish;
    end

endmodule

FILE: sim.f
design/hrcf_pkg.sv
design/hrcf_in_stage.sv
design/hrcf_run_tracker.sv
design/histogram_run_cluster_finder.sv
bench/histogram_run_cluster_finder_tb.sv
